@@ sv/prefix_code_key_decoder_macros.svh @@
// assertion macros for the prefix code key decoder
`ifndef PREFIX_CODE_KEY_DECODER_MACROS_SVH
`define PREFIX_CODE_KEY_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PCKD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define PCKD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PCKD_ASSERT_SAME(lbl, ante, cons, msg)
`define PCKD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/pckd_pkg.sv @@
// types and constants shared by the prefix code key decoder
`default_nettype none
package pckd_pkg;

	localparam int SLOT_W  = 6;
	localparam int CODE_W  = 16;
	localparam int LEN_W   = 5;
	localparam int KEY_W   = 8;
	localparam int COUNT_W = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [COUNT_W-1:0] COUNT_ONE = 8'h01;

	// request kinds
	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_BIT  = 1'b1
	} kind_t;

	// input request payload
	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  entry_slot;
		logic [CODE_W-1:0]  entry_code;
		logic [LEN_W-1:0]   entry_length;
		logic               entry_is_modifier;
		logic [KEY_W-1:0]   entry_key;
		logic               seq_bit;
		logic               seq_last;
	} item_t;

	// result payload
	typedef struct packed {
		logic               key_valid;
		logic [KEY_W-1:0]   key_id;
		logic [KEY_W-1:0]   modifier_mask;
		logic               last;
		logic [COUNT_W-1:0] key_count;
		logic               unused_bits;
		logic               code_overflow;
	} result_t;

endpackage
`default_nettype wire

@@ sv/pckd_if.sv @@
// valid/ready channel interfaces for requests and results
`default_nettype none
interface pckd_item_if;
	logic            valid;
	logic            ready;
	pckd_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pckd_result_if;
	logic              valid;
	logic              ready;
	pckd_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/prefix_code_key_decoder.sv @@
// two register stages: a request waits in the request register, its result in the result register
// throughput: one request per cycle while no result is held on the output; the code match over
//   all table entries is one parallel compare between the request register and the result register
// a result held on the output lets one more request into the request register, then
//   stalls the input until the result is taken, table loads included
// reset clears the table valid marks, the partial code and the per-sequence counters
`default_nettype none
`include "prefix_code_key_decoder_macros.svh"
module prefix_code_key_decoder #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_CODE_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	pckd_item_if.sink         item,
	pckd_result_if.source     result
);

	localparam int CW = MAX_CODE_BITS;
	localparam int W  = (CW > pckd_pkg::CODE_W) ? CW : pckd_pkg::CODE_W;
	localparam logic [pckd_pkg::LEN_W-1:0] LEN_MAX = pckd_pkg::LEN_W'(MAX_CODE_BITS);

	// request register
	logic            vld_s1;
	pckd_pkg::item_t item_s1;

	// result register
	logic              res_vld_s2;
	pckd_pkg::result_t res_s2;

	// code table
	logic [pckd_pkg::CODE_W-1:0] tbl_code_q [TABLE_ENTRIES];
	logic [pckd_pkg::LEN_W-1:0]  tbl_len_q  [TABLE_ENTRIES];
	logic                        tbl_mod_q  [TABLE_ENTRIES];
	logic [pckd_pkg::KEY_W-1:0]  tbl_key_q  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]    tbl_vld_q;

	// per-sequence state
	logic [CW-1:0]                pcode_q;
	logic [pckd_pkg::LEN_W-1:0]   plen_q;
	logic [pckd_pkg::KEY_W-1:0]   pmods_q;
	logic [pckd_pkg::COUNT_W-1:0] keys_q;
	logic                         ovf_q;

	logic s2_free;
	logic adv;
	logic is_bit;
	logic is_load;

	logic                        sat;
	logic [pckd_pkg::LEN_W-1:0]  new_len;
	logic [CW-1:0]               new_code;
	logic [W-1:0]                cmp_mask;
	logic [TABLE_ENTRIES-1:0]    hit_vec;
	logic [TABLE_ENTRIES-1:0]    first_hit;
	logic [pckd_pkg::KEY_W-1:0]  sel_key;
	logic                        sel_mod;
	logic                        any_hit;
	logic                        got_key;
	logic                        emit;

	logic [CW-1:0]                code_n;
	logic [pckd_pkg::LEN_W-1:0]   len_n;
	logic [pckd_pkg::KEY_W-1:0]   mods_n;
	logic [pckd_pkg::COUNT_W-1:0] keys_n;
	logic                         ovf_n;
	pckd_pkg::result_t            res_n;

	// handshake and stage advance
	assign s2_free    = !res_vld_s2 || result.ready;
	assign adv        = vld_s1 && s2_free;
	assign item.ready = !vld_s1 || s2_free;
	assign is_bit     = vld_s1 && (item_s1.kind == pckd_pkg::KIND_BIT);
	assign is_load    = vld_s1 && (item_s1.kind == pckd_pkg::KIND_LOAD);

	assign result.valid = res_vld_s2;
	assign result.data  = res_s2;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// table valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (adv && is_load) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (int'(item_s1.entry_slot) == i) begin
					tbl_vld_q[i] <= 1'b1;
				end
			end
		end
	end

	// table entry contents
	always_ff @(posedge clk) begin
		if (adv && is_load) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (int'(item_s1.entry_slot) == i) begin
					tbl_code_q[i] <= item_s1.entry_code;
					tbl_len_q[i]  <= item_s1.entry_length;
					tbl_mod_q[i]  <= item_s1.entry_is_modifier;
					tbl_key_q[i]  <= item_s1.entry_key;
				end
			end
		end
	end

	// grow the partial code by one bit
	assign sat      = (plen_q >= LEN_MAX);
	assign new_len  = plen_q + pckd_pkg::LEN_W'(1);
	assign new_code = pcode_q | (CW'(item_s1.seq_bit) << plen_q);
	assign cmp_mask = ~({W{1'b1}} << new_len);

	// parallel compare against every entry
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i] = tbl_vld_q[i] && (tbl_len_q[i] == new_len) &&
				((W'(tbl_code_q[i]) & cmp_mask) == W'(new_code));
		end
	end

	// lowest matching slot wins
	assign first_hit = hit_vec & (~hit_vec + TABLE_ENTRIES'(1));

	always_comb begin
		sel_key = '0;
		sel_mod = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sel_key = sel_key | ({pckd_pkg::KEY_W{first_hit[i]}} & tbl_key_q[i]);
			sel_mod = sel_mod | (first_hit[i] & tbl_mod_q[i]);
		end
	end

	assign any_hit = !sat && (|hit_vec);
	assign got_key = any_hit && !sel_mod;
	assign emit    = is_bit && (got_key || item_s1.seq_last);

	// next sequence state and result
	always_comb begin
		code_n = pcode_q;
		len_n  = plen_q;
		mods_n = pmods_q;
		keys_n = keys_q;
		ovf_n  = ovf_q;
		if (sat) begin
			ovf_n = 1'b1;
		end else if (any_hit) begin
			code_n = '0;
			len_n  = '0;
			if (sel_mod) begin
				mods_n = pmods_q | sel_key;
			end else begin
				mods_n = '0;
				if (keys_q != pckd_pkg::COUNT_MAX) begin
					keys_n = keys_q + pckd_pkg::COUNT_ONE;
				end
			end
		end else begin
			code_n = new_code;
			len_n  = new_len;
		end

		res_n.key_valid     = got_key;
		res_n.key_id        = got_key ? sel_key : '0;
		res_n.modifier_mask = got_key ? pmods_q : '0;
		res_n.last          = item_s1.seq_last;
		res_n.key_count     = item_s1.seq_last ? keys_n : '0;
		res_n.unused_bits   = item_s1.seq_last && (len_n != '0);
		res_n.code_overflow = item_s1.seq_last && ovf_n;

		// end of sequence clears everything
		if (item_s1.seq_last) begin
			code_n = '0;
			len_n  = '0;
			mods_n = '0;
			keys_n = '0;
			ovf_n  = 1'b0;
		end
	end

	// sequence state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcode_q <= '0;
			plen_q  <= '0;
			pmods_q <= '0;
			keys_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (adv && is_bit) begin
			pcode_q <= code_n;
			plen_q  <= len_n;
			pmods_q <= mods_n;
			keys_q  <= keys_n;
			ovf_q   <= ovf_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv) begin
			res_vld_s2 <= emit;
		end else if (result.ready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_s2 <= res_n;
		end
	end

	// checks
	`PCKD_ASSERT_SAME(a_mid_needs_key, res_vld_s2 && !res_s2.last, res_s2.key_valid, "result without key or end of sequence")
	`PCKD_ASSERT_SAME(a_nokey_zero, res_vld_s2 && !res_s2.key_valid, (res_s2.key_id == '0) && (res_s2.modifier_mask == '0), "key fields set without a key")
	`PCKD_ASSERT_SAME(a_summary_zero, res_vld_s2 && !res_s2.last, (res_s2.key_count == '0) && !res_s2.unused_bits && !res_s2.code_overflow, "summary fields set before the last bit")
	`PCKD_ASSERT_SAME(a_len_bound, 1'b1, plen_q <= LEN_MAX, "partial length past maximum code length")
	`PCKD_ASSERT_NEXT(a_last_clears, adv && is_bit && item_s1.seq_last, (plen_q == '0) && (keys_q == '0) && (pmods_q == '0) && !ovf_q, "sequence state not cleared after last bit")

endmodule
`default_nettype wire

@@ bench/prefix_code_key_decoder_tb.sv @@
// self-checking bench for the prefix code key decoder: table loads, bit streams, key reports
`timescale 1ns / 100ps
module prefix_code_key_decoder_tb;
	import pckd_pkg::*;

	localparam int TABLE_ENTRIES  = 64;
	localparam int MAX_CODE_BITS  = 16;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_LEN       = 400;
	localparam int HOLD_AT_FIRST  = 300;
	localparam int HOLD_AT_SECOND = 3000;

	// length mix of the code words loaded in one round
	typedef enum int {
		MIX_SHORT,
		MIX_ANY,
		MIX_LONG
	} code_mix_t;

	logic clk = 1'b0;
	logic arst_n;

	pckd_item_if   item_bus ();
	pckd_result_if result_bus ();

	prefix_code_key_decoder #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	item_t   request_backlog [$];
	result_t key_reports [$];
	int      error_count = 0;

	// decoder copy: code table and per-sequence state
	logic [CODE_W-1:0]  tbl_code [TABLE_ENTRIES];
	logic [LEN_W-1:0]   tbl_len [TABLE_ENTRIES];
	logic               tbl_mod [TABLE_ENTRIES];
	logic [KEY_W-1:0]   tbl_key [TABLE_ENTRIES];
	logic               tbl_valid [TABLE_ENTRIES];
	logic [CODE_W-1:0]  acc_code;
	int                 acc_len;
	logic [KEY_W-1:0]   acc_mods;
	logic [COUNT_W-1:0] key_total;
	logic               overflowed;

	// code words as loaded, used to build well-formed streams
	logic [CODE_W-1:0]  plan_code [TABLE_ENTRIES];
	logic [LEN_W-1:0]   plan_len [TABLE_ENTRIES];

	int unsigned send_wait, send_calm;
	int unsigned recv_wait, recv_calm, hold_left, recv_cycles;
	int unsigned quiet_cycles = 0;

	// apply one accepted request and queue the report it causes
	task automatic decode_request(input item_t req);
		int               hit;
		logic             got;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] mods;
		logic [31:0]      msk;
		result_t          rep;
		if (req.kind == KIND_LOAD) begin
			if (req.entry_slot < TABLE_ENTRIES) begin
				tbl_code[req.entry_slot]  = req.entry_code;
				tbl_len[req.entry_slot]   = req.entry_length;
				tbl_mod[req.entry_slot]   = req.entry_is_modifier;
				tbl_key[req.entry_slot]   = req.entry_key;
				tbl_valid[req.entry_slot] = 1'b1;
			end
		end else begin
			got  = 1'b0;
			key  = '0;
			mods = '0;
			if (acc_len >= MAX_CODE_BITS) begin
				overflowed = 1'b1;
			end else begin
				acc_code[acc_len] = req.seq_bit;
				acc_len++;
				hit = -1;
				// lowest matching slot wins
				for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++) begin
					if (tbl_valid[i] && tbl_len[i] != 0 && tbl_len[i] <= MAX_CODE_BITS &&
							tbl_len[i] == acc_len) begin
						msk = (32'h1 << tbl_len[i]) - 32'h1;
						if (({16'h0, tbl_code[i]} & msk) == ({16'h0, acc_code} & msk))
							hit = i;
					end
				end
				if (hit >= 0) begin
					if (tbl_mod[hit]) begin
						acc_mods = acc_mods | tbl_key[hit];
					end else begin
						got      = 1'b1;
						key      = tbl_key[hit];
						mods     = acc_mods;
						acc_mods = '0;
						if (key_total != COUNT_MAX)
							key_total = key_total + COUNT_ONE;
					end
					acc_code = '0;
					acc_len  = 0;
				end
			end
			if (got || req.seq_last) begin
				rep               = '0;
				rep.key_valid     = got;
				rep.key_id        = key;
				rep.modifier_mask = mods;
				rep.last          = req.seq_last;
				if (req.seq_last) begin
					rep.key_count     = key_total;
					rep.unused_bits   = (acc_len > 0);
					rep.code_overflow = overflowed;
				end
				key_reports.push_back(rep);
			end
			if (req.seq_last) begin
				acc_code   = '0;
				acc_len    = 0;
				acc_mods   = '0;
				key_total  = '0;
				overflowed = 1'b0;
			end
		end
	endtask

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	function automatic void compare_field(input string label, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, label, want, got);
			error_count++;
		end
	endfunction

	// table load request, ignored stream fields random
	task automatic push_load(input logic [SLOT_W-1:0] slot, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len, input logic is_mod, input logic [KEY_W-1:0] key);
		item_t       req;
		logic [63:0] noise;
		noise                 = {$urandom, $urandom};
		req                   = noise[$bits(item_t)-1:0];
		req.kind              = KIND_LOAD;
		req.entry_slot        = slot;
		req.entry_code        = code;
		req.entry_length      = len;
		req.entry_is_modifier = is_mod;
		req.entry_key         = key;
		plan_code[slot]       = code;
		plan_len[slot]        = len;
		request_backlog.push_back(req);
	endtask

	// stream bit request, ignored entry fields random
	task automatic push_bit(input logic b, input logic fin);
		item_t       req;
		logic [63:0] noise;
		noise        = {$urandom, $urandom};
		req          = noise[$bits(item_t)-1:0];
		req.kind     = KIND_BIT;
		req.seq_bit  = b;
		req.seq_last = fin;
		request_backlog.push_back(req);
	endtask

	// random table entry; a few never match (length zero or too long)
	task automatic push_random_load(input code_mix_t mix, input int unsigned slot);
		int unsigned r;
		int unsigned len;
		r = $urandom_range(0, 19);
		if (r == 0)
			len = 0;
		else if (r == 1)
			len = $urandom_range(MAX_CODE_BITS + 1, 31);
		else begin
			case (mix)
				MIX_SHORT: len = $urandom_range(1, 6);
				MIX_ANY:   len = $urandom_range(1, MAX_CODE_BITS);
				default:   len = $urandom_range(10, MAX_CODE_BITS);
			endcase
		end
		push_load(SLOT_W'(slot), CODE_W'($urandom), LEN_W'(len), ($urandom_range(0, 3) == 0),
			KEY_W'($urandom));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		int unsigned gap;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			item_bus.data  <= '0;
			send_wait      <= 0;
			send_calm      <= 0;
		end else begin
			// a request taken at this edge updates the expected reports
			if (item_bus.valid && item_bus.ready)
				decode_request(item_bus.data);
			// offer the next request once the current one is gone
			if (!item_bus.valid || item_bus.ready) begin
				if (send_wait > 0) begin
					send_wait      <= send_wait - 1;
					item_bus.valid <= 1'b0;
				end else if (request_backlog.size() > 0) begin
					item_bus.data  <= request_backlog.pop_front();
					item_bus.valid <= 1'b1;
					if (send_calm > 0) begin
						send_calm <= send_calm - 1;
						gap = 0;
					end else begin
						gap = idle_len();
						if ($urandom_range(0, 39) == 0)
							send_calm <= $urandom_range(30, 150);
					end
					send_wait <= gap;
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : collect_proc
		int unsigned gap;
		result_t     want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			recv_wait        <= 0;
			recv_calm        <= 0;
			hold_left        <= 0;
			recv_cycles      <= 0;
		end else begin
			recv_cycles <= recv_cycles + 1;
			// compare with the oldest expected report
			if (result_bus.valid && result_bus.ready) begin
				if (key_reports.size() == 0) begin
					$display("%0t: expected no result, actual key_valid=%0b key=%0h last=%0b",
						$time, result_bus.data.key_valid, result_bus.data.key_id,
						result_bus.data.last);
					error_count++;
				end else begin
					want = key_reports.pop_front();
					compare_field("key_valid", want.key_valid, result_bus.data.key_valid);
					compare_field("key_id", want.key_id, result_bus.data.key_id);
					compare_field("modifier_mask", want.modifier_mask,
						result_bus.data.modifier_mask);
					compare_field("last", want.last, result_bus.data.last);
					compare_field("key_count", want.key_count, result_bus.data.key_count);
					compare_field("unused_bits", want.unused_bits, result_bus.data.unused_bits);
					compare_field("code_overflow", want.code_overflow,
						result_bus.data.code_overflow);
				end
			end
			// long hold-offs so the block backs up into its input
			if (hold_left > 0) begin
				hold_left        <= hold_left - 1;
				result_bus.ready <= 1'b0;
			end else if (recv_cycles == HOLD_AT_FIRST || recv_cycles == HOLD_AT_SECOND) begin
				hold_left        <= HOLD_LEN;
				result_bus.ready <= 1'b0;
			end else if (result_bus.valid && result_bus.ready) begin
				if (recv_calm > 0) begin
					recv_calm <= recv_calm - 1;
					gap = 0;
				end else begin
					gap = idle_len();
					if ($urandom_range(0, 39) == 0)
						recv_calm <= $urandom_range(30, 150);
				end
				result_bus.ready <= (gap == 0);
				recv_wait        <= (gap == 0) ? 0 : gap - 1;
			end else if (recv_wait > 0) begin
				recv_wait        <= recv_wait - 1;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(0, 9) != 0);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin : stimulus
		bit                seq_bits [$];
		code_mix_t         mix;
		int unsigned       slot, tries, base, round;
		logic [CODE_W-1:0] sat_code;
		item_bus.valid   = 1'b0;
		item_bus.data    = '0;
		result_bus.ready = 1'b0;
		arst_n           = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_code[i]  = '0;
			tbl_len[i]   = '0;
			tbl_mod[i]   = 1'b0;
			tbl_key[i]   = '0;
			tbl_valid[i] = 1'b0;
			plan_code[i] = '0;
			plan_len[i]  = '0;
		end
		acc_code   = '0;
		acc_len    = 0;
		acc_mods   = '0;
		key_total  = '0;
		overflowed = 1'b0;

		// empty table: lone final bit is unused
		push_bit(1'b1, 1'b1);
		// extreme entries, shadowed duplicate, entries that can never match
		push_load(6'd63, 16'hFFFF, 5'd16, 1'b1, 8'hFF);
		push_load(6'd0, 16'h0000, 5'd1, 1'b0, 8'h00);
		push_load(6'd1, 16'h0001, 5'd2, 1'b1, 8'h81);
		push_load(6'd2, 16'h0003, 5'd2, 1'b0, 8'h5A);
		push_load(6'd5, 16'h0003, 5'd2, 1'b0, 8'hA5);
		push_load(6'd3, 16'h0000, 5'd0, 1'b0, 8'h77);
		push_load(6'd4, 16'hFFFF, 5'd31, 1'b0, 8'h66);
		// modifier, key with mask, key on the final bit
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b1, 1'b0);
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b1);
		// modifier carried into a key on the final bit
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b0, 1'b1);
		// modifier dropped at the end, trailing bit unused
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b1, 1'b1);

		// random rounds: fresh table contents, then mostly well-formed streams
		base  = request_backlog.size();
		round = 0;
		while (request_backlog.size() < base + RANDOM_ITEMS) begin
			mix = code_mix_t'($urandom_range(0, 2));
			if (round == 0) begin
				// one long stream of one-bit keys to saturate the key count
				sat_code    = CODE_W'($urandom);
				sat_code[0] = 1'b0;
				push_load(6'd0, sat_code, 5'd1, 1'b0, KEY_W'($urandom));
				repeat (300)
					push_bit(1'b0, 1'b0);
				push_bit(1'b0, 1'b1);
			end
			push_random_load(mix, 0);
			repeat ($urandom_range(8, 40))
				push_random_load(mix, $urandom_range(0, TABLE_ENTRIES - 1));
			repeat ($urandom_range(10, 30)) begin
				// stop at the item budget, always between whole streams
				if (request_backlog.size() >= base + RANDOM_ITEMS)
					break;
				seq_bits.delete();
				if ($urandom_range(0, 9) == 0) begin
					// broken stream of random bits
					repeat ($urandom_range(1, 24))
						seq_bits.push_back(1'($urandom_range(0, 1)));
				end else begin
					repeat ($urandom_range(1, 8)) begin
						if ($urandom_range(0, 9) == 0)
							seq_bits.push_back(1'($urandom_range(0, 1)));
						tries = 0;
						slot  = $urandom_range(0, TABLE_ENTRIES - 1);
						while ((plan_len[slot] == 0 || plan_len[slot] > MAX_CODE_BITS) &&
								tries < 20) begin
							slot = $urandom_range(0, TABLE_ENTRIES - 1);
							tries++;
						end
						if (plan_len[slot] != 0 && plan_len[slot] <= MAX_CODE_BITS) begin
							for (int b = 0; b < plan_len[slot]; b++)
								seq_bits.push_back(plan_code[slot][b]);
						end else begin
							seq_bits.push_back(1'($urandom_range(0, 1)));
						end
					end
					if ($urandom_range(0, 7) == 0)
						seq_bits.push_back(1'($urandom_range(0, 1)));
				end
				// occasional table update in the middle of a stream
				foreach (seq_bits[b]) begin
					if ($urandom_range(0, 29) == 0)
						push_random_load(mix, $urandom_range(0, TABLE_ENTRIES - 1));
					push_bit(seq_bits[b], b == seq_bits.size() - 1);
				end
			end
			round++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// drain: everything sent, every report seen, then a short wait before the verdict
		while (request_backlog.size() != 0 || item_bus.valid)
			@(posedge clk);
		while (key_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
